// ----- rtl/complex_arith_unit_core_assert.svh -----
// ----------------------------------------------------------------------------
// complex_arith_unit_core_assert.svh
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_CORE_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// shared types and defaults of the complex arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    localparam int WORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 12;

    typedef enum logic [2:0] {
        ACT_ADD  = 3'd0,
        ACT_SUB  = 3'd1,
        ACT_MUL  = 3'd2,
        ACT_DIV  = 3'd3,
        ACT_CONJ = 3'd4
    } act_t;

    typedef struct packed {
        logic vld;
        act_t act;
        logic dz;
        logic oth_sat;
        logic neg_re;
        logic neg_im;
        logic big_re;
        logic big_im;
    } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/cau_front.sv -----
// ----------------------------------------------------------------------------
// cau_front
// products, sums, clipping of the direct actions and quotient setup
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front #(
    parameter int WORD_BITS = 16,
    parameter int FRAC_BITS = 12
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          ce,
    input  wire logic                          in_vld,
    input  wire logic [2:0]                    action,
    input  wire logic signed [WORD_BITS-1:0]   a_re,
    input  wire logic signed [WORD_BITS-1:0]   a_im,
    input  wire logic signed [WORD_BITS-1:0]   b_re,
    input  wire logic signed [WORD_BITS-1:0]   b_im,
    output cau_pkg::ctl_t                      ctl_o,
    output logic [WORD_BITS-1:0]               oth_re_o,
    output logic [WORD_BITS-1:0]               oth_im_o,
    output logic [3*WORD_BITS+FRAC_BITS+1:0]   rem_re_o,
    output logic [3*WORD_BITS+FRAC_BITS+1:0]   rem_im_o,
    output logic [2*WORD_BITS-1:0]             den_o
);
    import cau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int RW = 3 * W + FRAC_BITS + 2;
    localparam logic signed [SW-1:0] ONE_S = 1;
    localparam logic signed [SW-1:0] MAXV  = (ONE_S <<< (W - 1)) - ONE_S;
    localparam logic signed [SW-1:0] MINV  = -(ONE_S <<< (W - 1));

    function automatic logic [W:0] clip_w(input logic signed [SW-1:0] v);
        logic [W:0] r;
        if (v > MAXV) begin
            r = {1'b1, MAXV[W-1:0]};
        end else if (v < MINV) begin
            r = {1'b1, MINV[W-1:0]};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    // stage a: products
    logic                 vld_a_reg;
    act_t                 act_a_reg;
    logic signed [W-1:0]  are_a_reg, aim_a_reg, bre_a_reg, bim_a_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
        end else if (ce) begin
            vld_a_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            act_a_reg <= act_t'(action);
            are_a_reg <= a_re;
            aim_a_reg <= a_im;
            bre_a_reg <= b_re;
            bim_a_reg <= b_im;
            p_rr_reg  <= PW'(a_re) * PW'(b_re);
            p_ii_reg  <= PW'(a_im) * PW'(b_im);
            p_ri_reg  <= PW'(a_re) * PW'(b_im);
            p_ir_reg  <= PW'(a_im) * PW'(b_re);
            p_bb_reg  <= PW'(b_re) * PW'(b_re);
            p_cc_reg  <= PW'(b_im) * PW'(b_im);
        end
    end

    // stage b: sums and direct results
    ctl_t                 ctl_b_reg, ctl_b_next;
    logic [W-1:0]         oth_re_b_reg, oth_im_b_reg, oth_re_b_next, oth_im_b_next;
    logic [PW-1:0]        mag_re_b_reg, mag_im_b_reg, mag_re_b_next, mag_im_b_next;
    logic [PW-1:0]        den_b_reg, den_b_next;
    logic signed [SW-1:0] num_re, num_im, mul_re, mul_im, neg_re_v, neg_im_v;
    logic [W:0]           c_re, c_im;

    always_comb begin
        num_re   = SW'(p_rr_reg) + SW'(p_ii_reg);
        num_im   = SW'(p_ir_reg) - SW'(p_ri_reg);
        mul_re   = (SW'(p_rr_reg) - SW'(p_ii_reg)) >>> FRAC_BITS;
        mul_im   = (SW'(p_ri_reg) + SW'(p_ir_reg)) >>> FRAC_BITS;
        neg_re_v = -num_re;
        neg_im_v = -num_im;
        den_b_next = PW'($unsigned(p_bb_reg) + $unsigned(p_cc_reg));
        mag_re_b_next = num_re[SW-1] ? neg_re_v[PW-1:0] : num_re[PW-1:0];
        mag_im_b_next = num_im[SW-1] ? neg_im_v[PW-1:0] : num_im[PW-1:0];
        unique case (act_a_reg)
            ACT_ADD: begin
                c_re = clip_w(SW'(are_a_reg) + SW'(bre_a_reg));
                c_im = clip_w(SW'(aim_a_reg) + SW'(bim_a_reg));
            end
            ACT_SUB: begin
                c_re = clip_w(SW'(are_a_reg) - SW'(bre_a_reg));
                c_im = clip_w(SW'(aim_a_reg) - SW'(bim_a_reg));
            end
            ACT_MUL: begin
                c_re = clip_w(mul_re);
                c_im = clip_w(mul_im);
            end
            ACT_CONJ: begin
                c_re = {1'b0, are_a_reg};
                c_im = clip_w(-SW'(aim_a_reg));
            end
            default: begin
                c_re = '0;
                c_im = '0;
            end
        endcase
        oth_re_b_next      = c_re[W-1:0];
        oth_im_b_next      = c_im[W-1:0];
        ctl_b_next.vld     = vld_a_reg;
        ctl_b_next.act     = act_a_reg;
        ctl_b_next.dz      = (den_b_next == '0);
        ctl_b_next.oth_sat = c_re[W] | c_im[W];
        ctl_b_next.neg_re  = num_re[SW-1];
        ctl_b_next.neg_im  = num_im[SW-1];
        ctl_b_next.big_re  = 1'b0;
        ctl_b_next.big_im  = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_b_reg.vld <= 1'b0;
        end else if (ce) begin
            ctl_b_reg.vld <= ctl_b_next.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctl_b_reg.act     <= ctl_b_next.act;
            ctl_b_reg.dz      <= ctl_b_next.dz;
            ctl_b_reg.oth_sat <= ctl_b_next.oth_sat;
            ctl_b_reg.neg_re  <= ctl_b_next.neg_re;
            ctl_b_reg.neg_im  <= ctl_b_next.neg_im;
            ctl_b_reg.big_re  <= ctl_b_next.big_re;
            ctl_b_reg.big_im  <= ctl_b_next.big_im;
            oth_re_b_reg      <= oth_re_b_next;
            oth_im_b_reg      <= oth_im_b_next;
            mag_re_b_reg      <= mag_re_b_next;
            mag_im_b_reg      <= mag_im_b_next;
            den_b_reg         <= den_b_next;
        end
    end

    // stage c: dividend and quotient range check
    ctl_t          ctl_c_reg, ctl_c_next;
    logic [W-1:0]  oth_re_c_reg, oth_im_c_reg;
    logic [RW-1:0] rem_re_c_reg, rem_im_c_reg, rem_re_c_next, rem_im_c_next;
    logic [PW-1:0] den_c_reg;
    logic [RW-1:0] d_re, d_im, d_lim;

    always_comb begin
        d_re  = RW'(mag_re_b_reg) << FRAC_BITS;
        d_im  = RW'(mag_im_b_reg) << FRAC_BITS;
        d_lim = RW'(den_b_reg) << (W + 1);
        ctl_c_next        = ctl_b_reg;
        ctl_c_next.big_re = (d_re >= d_lim);
        ctl_c_next.big_im = (d_im >= d_lim);
        rem_re_c_next     = ctl_c_next.big_re ? '0 : d_re;
        rem_im_c_next     = ctl_c_next.big_im ? '0 : d_im;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_c_reg.vld <= 1'b0;
        end else if (ce) begin
            ctl_c_reg.vld <= ctl_c_next.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctl_c_reg.act     <= ctl_c_next.act;
            ctl_c_reg.dz      <= ctl_c_next.dz;
            ctl_c_reg.oth_sat <= ctl_c_next.oth_sat;
            ctl_c_reg.neg_re  <= ctl_c_next.neg_re;
            ctl_c_reg.neg_im  <= ctl_c_next.neg_im;
            ctl_c_reg.big_re  <= ctl_c_next.big_re;
            ctl_c_reg.big_im  <= ctl_c_next.big_im;
            oth_re_c_reg      <= oth_re_b_reg;
            oth_im_c_reg      <= oth_im_b_reg;
            rem_re_c_reg      <= rem_re_c_next;
            rem_im_c_reg      <= rem_im_c_next;
            den_c_reg         <= den_b_reg;
        end
    end

    assign ctl_o    = ctl_c_reg;
    assign oth_re_o = oth_re_c_reg;
    assign oth_im_o = oth_im_c_reg;
    assign rem_re_o = rem_re_c_reg;
    assign rem_im_o = rem_im_c_reg;
    assign den_o    = den_c_reg;

endmodule

`default_nettype wire

// ----- rtl/cau_div_step.sv -----
// ----------------------------------------------------------------------------
// cau_div_step
// one restoring quotient bit for the real and imaginary parts
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_step #(
    parameter int WORD_BITS = 16,
    parameter int FRAC_BITS = 12,
    parameter int SHIFT     = 0
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          ce,
    input  wire cau_pkg::ctl_t                 ctl_i,
    input  wire logic [WORD_BITS-1:0]          oth_re_i,
    input  wire logic [WORD_BITS-1:0]          oth_im_i,
    input  wire logic [3*WORD_BITS+FRAC_BITS+1:0] rem_re_i,
    input  wire logic [3*WORD_BITS+FRAC_BITS+1:0] rem_im_i,
    input  wire logic [2*WORD_BITS-1:0]        den_i,
    input  wire logic [WORD_BITS:0]            q_re_i,
    input  wire logic [WORD_BITS:0]            q_im_i,
    output cau_pkg::ctl_t                      ctl_o,
    output logic [WORD_BITS-1:0]               oth_re_o,
    output logic [WORD_BITS-1:0]               oth_im_o,
    output logic [3*WORD_BITS+FRAC_BITS+1:0]   rem_re_o,
    output logic [3*WORD_BITS+FRAC_BITS+1:0]   rem_im_o,
    output logic [2*WORD_BITS-1:0]             den_o,
    output logic [WORD_BITS:0]                 q_re_o,
    output logic [WORD_BITS:0]                 q_im_o
);
    import cau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int RW = 3 * W + FRAC_BITS + 2;
    localparam logic [W:0] QBIT = (W+1)'(1) << SHIFT;

    ctl_t          ctl_reg;
    logic [W-1:0]  oth_re_reg, oth_im_reg;
    logic [RW-1:0] rem_re_reg, rem_im_reg, rem_re_next, rem_im_next;
    logic [2*W-1:0] den_reg;
    logic [W:0]    q_re_reg, q_im_reg, q_re_next, q_im_next;
    logic [RW-1:0] dsh;

    always_comb begin
        dsh = RW'(den_i) << SHIFT;
        if (rem_re_i >= dsh) begin
            rem_re_next = rem_re_i - dsh;
            q_re_next   = q_re_i | QBIT;
        end else begin
            rem_re_next = rem_re_i;
            q_re_next   = q_re_i;
        end
        if (rem_im_i >= dsh) begin
            rem_im_next = rem_im_i - dsh;
            q_im_next   = q_im_i | QBIT;
        end else begin
            rem_im_next = rem_im_i;
            q_im_next   = q_im_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.vld <= 1'b0;
        end else if (ce) begin
            ctl_reg.vld <= ctl_i.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctl_reg.act     <= ctl_i.act;
            ctl_reg.dz      <= ctl_i.dz;
            ctl_reg.oth_sat <= ctl_i.oth_sat;
            ctl_reg.neg_re  <= ctl_i.neg_re;
            ctl_reg.neg_im  <= ctl_i.neg_im;
            ctl_reg.big_re  <= ctl_i.big_re;
            ctl_reg.big_im  <= ctl_i.big_im;
            oth_re_reg      <= oth_re_i;
            oth_im_reg      <= oth_im_i;
            rem_re_reg      <= rem_re_next;
            rem_im_reg      <= rem_im_next;
            den_reg         <= den_i;
            q_re_reg        <= q_re_next;
            q_im_reg        <= q_im_next;
        end
    end

    assign ctl_o    = ctl_reg;
    assign oth_re_o = oth_re_reg;
    assign oth_im_o = oth_im_reg;
    assign rem_re_o = rem_re_reg;
    assign rem_im_o = rem_im_reg;
    assign den_o    = den_reg;
    assign q_re_o   = q_re_reg;
    assign q_im_o   = q_im_reg;

endmodule

`default_nettype wire

// ----- rtl/complex_arith_unit_core.sv -----
// ----------------------------------------------------------------------------
// complex_arith_unit_core
// pipelined complex add, subtract, multiply, divide and conjugate
//
//   channel   ports                                   dir
//   s_        s_valid s_ready s_action s_a_* s_b_*    in
//   m_        m_valid m_ready m_res_* m_saturated     out
//             m_div_by_zero
//
// one word per cycle while the output word is not held; the quotient
// pipeline of WORD_BITS+1 restoring stages sits behind three front stages
// the whole pipe advances together; it holds when the output word waits
// synchronous active-low reset clears all valid bits
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit_core #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [2:0]                  s_action,
    input  wire logic signed [WORD_BITS-1:0] s_a_re,
    input  wire logic signed [WORD_BITS-1:0] s_a_im,
    input  wire logic signed [WORD_BITS-1:0] s_b_re,
    input  wire logic signed [WORD_BITS-1:0] s_b_im,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [WORD_BITS-1:0]      m_res_re,
    output logic signed [WORD_BITS-1:0]      m_res_im,
    output logic                             m_saturated,
    output logic                             m_div_by_zero
);
    import cau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int RW = 3 * W + FRAC_BITS + 2;
    localparam int NS = W + 2;
    localparam logic [W:0] HALF = (W+1)'(1) << (W - 1);
    localparam logic [W:0] MAXQ = HALF - (W+1)'(1);

    logic ce;
    assign ce      = m_ready | ~m_valid;
    assign s_ready = ce;

    ctl_t          ctl_s    [NS];
    logic [W-1:0]  oth_re_s [NS];
    logic [W-1:0]  oth_im_s [NS];
    logic [RW-1:0] rem_re_s [NS];
    logic [RW-1:0] rem_im_s [NS];
    logic [2*W-1:0] den_s   [NS];
    logic [W:0]    q_re_s   [NS];
    logic [W:0]    q_im_s   [NS];

    cau_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_vld   (s_valid),
        .action   (s_action),
        .a_re     (s_a_re),
        .a_im     (s_a_im),
        .b_re     (s_b_re),
        .b_im     (s_b_im),
        .ctl_o    (ctl_s[0]),
        .oth_re_o (oth_re_s[0]),
        .oth_im_o (oth_im_s[0]),
        .rem_re_o (rem_re_s[0]),
        .rem_im_o (rem_im_s[0]),
        .den_o    (den_s[0])
    );

    assign q_re_s[0] = '0;
    assign q_im_s[0] = '0;

    for (genvar k = 0; k <= W; k++) begin : g_div
        cau_div_step #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS),
            .SHIFT     (W - k)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ce       (ce),
            .ctl_i    (ctl_s[k]),
            .oth_re_i (oth_re_s[k]),
            .oth_im_i (oth_im_s[k]),
            .rem_re_i (rem_re_s[k]),
            .rem_im_i (rem_im_s[k]),
            .den_i    (den_s[k]),
            .q_re_i   (q_re_s[k]),
            .q_im_i   (q_im_s[k]),
            .ctl_o    (ctl_s[k+1]),
            .oth_re_o (oth_re_s[k+1]),
            .oth_im_o (oth_im_s[k+1]),
            .rem_re_o (rem_re_s[k+1]),
            .rem_im_o (rem_im_s[k+1]),
            .den_o    (den_s[k+1]),
            .q_re_o   (q_re_s[k+1]),
            .q_im_o   (q_im_s[k+1])
        );
    end

    // output stage
    ctl_t         cf;
    logic [W-1:0] dre, dim, neg_q_re, neg_q_im;
    logic         sre, sim;
    logic         vld_reg;
    logic [W-1:0] re_reg, im_reg, re_next, im_next;
    logic         sat_reg, dz_reg, sat_next, dz_next;

    always_comb begin
        cf       = ctl_s[NS-1];
        neg_q_re = -q_re_s[NS-1][W-1:0];
        neg_q_im = -q_im_s[NS-1][W-1:0];
        if (!cf.neg_re) begin
            sre = cf.big_re | (q_re_s[NS-1] > MAXQ);
            dre = sre ? MAXQ[W-1:0] : q_re_s[NS-1][W-1:0];
        end else begin
            sre = cf.big_re | (q_re_s[NS-1] > HALF);
            dre = sre ? HALF[W-1:0] : neg_q_re;
        end
        if (!cf.neg_im) begin
            sim = cf.big_im | (q_im_s[NS-1] > MAXQ);
            dim = sim ? MAXQ[W-1:0] : q_im_s[NS-1][W-1:0];
        end else begin
            sim = cf.big_im | (q_im_s[NS-1] > HALF);
            dim = sim ? HALF[W-1:0] : neg_q_im;
        end
        if (cf.act == ACT_DIV) begin
            re_next  = cf.dz ? '0 : dre;
            im_next  = cf.dz ? '0 : dim;
            sat_next = ~cf.dz & (sre | sim);
            dz_next  = cf.dz;
        end else begin
            re_next  = oth_re_s[NS-1];
            im_next  = oth_im_s[NS-1];
            sat_next = cf.oth_sat;
            dz_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (ce) begin
            vld_reg <= cf.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            sat_reg <= sat_next;
            dz_reg  <= dz_next;
        end
    end

    assign m_valid       = vld_reg;
    assign m_res_re      = re_reg;
    assign m_res_im      = im_reg;
    assign m_saturated   = sat_reg;
    assign m_div_by_zero = dz_reg;

endmodule

`default_nettype wire

// ----- rtl/cau_checker.sv -----
// ----------------------------------------------------------------------------
// cau_checker
// port-level checks of the complex arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_arith_unit_core_assert.svh"

module cau_checker #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic signed [WORD_BITS-1:0] m_res_re,
    input wire logic signed [WORD_BITS-1:0] m_res_im,
    input wire logic                        m_saturated,
    input wire logic                        m_div_by_zero
);
    localparam logic [WORD_BITS-1:0] MINW = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] MAXW = {1'b0, {(WORD_BITS-1){1'b1}}};

    // output word holds while stalled
    `CAU_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_res_re) && $stable(m_res_im), "output word changed while stalled")

    // an empty output stage never blocks input
    `CAU_ASSERT_IMP(a_ready_empty, !m_valid, s_ready, "input blocked with empty output")

    // zero divisor gives zero result and no clip
    `CAU_ASSERT_IMP(a_dz_zero, m_valid && m_div_by_zero, m_res_re == '0 && m_res_im == '0 && !m_saturated, "divide by zero result not zero")

    // a clipped part sits at a range limit
    `CAU_ASSERT_IMP(a_sat_limit, m_valid && m_saturated, m_res_re == MINW || m_res_re == MAXW || m_res_im == MINW || m_res_im == MAXW, "saturated flag without limit value")

endmodule

bind complex_arith_unit_core cau_checker #(.WORD_BITS(WORD_BITS)) u_cau_checker (.*);

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the complex arithmetic unit: a directed table of
// extremes, flags and unused codes, then random words with random stalls on
// both channels, each result compared against the table's expected value or an in-bench fixed-point model
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import cau_pkg::*;

    localparam int WB = WORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int N_RANDOM = 700;
    localparam int DRAIN = WB + 20;

    typedef struct {
        logic [2:0]           act;
        logic signed [WB-1:0] a_re, a_im, b_re, b_im;
    } operands_t;

    typedef struct {
        logic signed [WB-1:0] re, im;
        logic                 sat, dz;
    } cplx_result_t;

    typedef struct {
        operands_t    op;
        bit           typed;
        cplx_result_t res;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [2:0]           s_action = '0;
    logic signed [WB-1:0] s_a_re = '0, s_a_im = '0, s_b_re = '0, s_b_im = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [WB-1:0] m_res_re, m_res_im;
    logic                 m_saturated, m_div_by_zero;

    cplx_result_t pending_results[$];
    int           n_errors = 0;
    bit           calm = 1'b0;
    bit           typed_next = 1'b0;
    cplx_result_t typed_res;

    complex_arith_unit_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_a_re(s_a_re), .s_a_im(s_a_im), .s_b_re(s_b_re), .s_b_im(s_b_im),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_res_re(m_res_re), .m_res_im(m_res_im),
        .m_saturated(m_saturated), .m_div_by_zero(m_div_by_zero)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clamp(longint v, inout logic sat);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (WB - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // floor(|n| * 2^FB / den), sign applied afterwards: truncation toward zero
    function automatic longint quot(longint n, longint den);
        longint m;
        m = (n < 0) ? -n : n;
        m = (m <<< FB) / den;
        return (n < 0) ? -m : m;
    endfunction

    function automatic cplx_result_t complex_op(operands_t op);
        cplx_result_t r;
        longint ar, ai, br, bi, rr, ri, den;
        logic sat;
        ar = op.a_re;
        ai = op.a_im;
        br = op.b_re;
        bi = op.b_im;
        rr = 0;
        ri = 0;
        sat = 1'b0;
        r.dz = 1'b0;
        case (op.act)
            ACT_ADD: begin
                rr = clamp(ar + br, sat);
                ri = clamp(ai + bi, sat);
            end
            ACT_SUB: begin
                rr = clamp(ar - br, sat);
                ri = clamp(ai - bi, sat);
            end
            ACT_MUL: begin
                rr = clamp((ar * br - ai * bi) >>> FB, sat);
                ri = clamp((ar * bi + ai * br) >>> FB, sat);
            end
            ACT_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    rr = clamp(quot(ar * br + ai * bi, den), sat);
                    ri = clamp(quot(ai * br - ar * bi, den), sat);
                end
            end
            ACT_CONJ: begin
                rr = ar;
                ri = clamp(-ai, sat);
            end
            default: ;
        endcase
        r.re = rr[WB-1:0];
        r.im = ri[WB-1:0];
        r.sat = sat;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            if (typed_next)
                pending_results.push_back(typed_res);
            else
                pending_results.push_back(complex_op('{s_action, s_a_re, s_a_im,
                                                       s_b_re, s_b_im}));
        end
    end

    always @(posedge aclk) begin
        cplx_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation pending");
                n_errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_res_re !== e.re) begin
                    $error("res_re: expected %0d, got %0d", e.re, m_res_re);
                    n_errors++;
                end
                if (m_res_im !== e.im) begin
                    $error("res_im: expected %0d, got %0d", e.im, m_res_im);
                    n_errors++;
                end
                if (m_saturated !== e.sat) begin
                    $error("saturated: expected %0b, got %0b", e.sat, m_saturated);
                    n_errors++;
                end
                if (m_div_by_zero !== e.dz) begin
                    $error("div_by_zero: expected %0b, got %0b", e.dz, m_div_by_zero);
                    n_errors++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 6);
    end

    task automatic send_word(operands_t op, bit typed, cplx_result_t res);
        s_valid <= 1'b1;
        s_action <= op.act;
        s_a_re <= op.a_re;
        s_a_im <= op.a_im;
        s_b_re <= op.b_re;
        s_b_im <= op.b_im;
        typed_next <= typed;
        typed_res <= res;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    function automatic logic signed [WB-1:0] rand_part();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return WB'($urandom_range(8191)) - 16'sd4096;
            3: return WB'($urandom_range(3)) - 16'sd1;
            default: return WB'($urandom);
        endcase
    endfunction

    row_t table_rows[] = '{
        '{'{ACT_ADD, 0, 0, 0, 0}, 1, '{0, 0, 0, 0}},
        '{'{ACT_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1,
          '{16'sh7fff, 16'sh7fff, 1, 0}},
        '{'{ACT_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1,
          '{16'sh8000, 16'sh8000, 1, 0}},
        '{'{ACT_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000}, 1,
          '{16'sh8000, 16'sh7fff, 1, 0}},
        '{'{ACT_SUB, 16'sh1234, -16'sd5, 16'sh0234, 16'sd7}, 0, '{0, 0, 0, 0}},
        '{'{ACT_MUL, 16'sh1000, 0, 16'sh1000, 0}, 1, '{16'sh1000, 0, 0, 0}},
        '{'{ACT_MUL, -16'sd1, 0, 16'sd1, 0}, 1, '{-16'sd1, 0, 0, 0}},
        '{'{ACT_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 0, '{0, 0, 0, 0}},
        '{'{ACT_MUL, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff}, 0, '{0, 0, 0, 0}},
        '{'{ACT_DIV, 16'sh7fff, 16'sh8000, 0, 0}, 1, '{0, 0, 0, 1}},
        '{'{ACT_DIV, 16'sh1000, 0, 16'sh1000, 0}, 1, '{16'sh1000, 0, 0, 0}},
        '{'{ACT_DIV, 16'sh7fff, 16'sh7fff, 16'sd1, 0}, 0, '{0, 0, 0, 0}},
        '{'{ACT_DIV, -16'sd1, 0, 16'sh7fff, 0}, 0, '{0, 0, 0, 0}},
        '{'{ACT_DIV, 16'sh8000, 16'sh8000, 0, 16'sh8000}, 0, '{0, 0, 0, 0}},
        '{'{ACT_DIV, 16'sh0800, -16'sh0400, 16'sh8000, 16'sh7fff}, 0, '{0, 0, 0, 0}},
        '{'{ACT_CONJ, 16'sh0123, 16'sh8000, 16'sh7fff, 16'sh7fff}, 1,
          '{16'sh0123, 16'sh7fff, 1, 0}},
        '{'{ACT_CONJ, 16'sh8000, 16'sh7fff, 0, 0}, 0, '{0, 0, 0, 0}},
        '{'{3'd5, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1, '{0, 0, 0, 0}},
        '{'{3'd6, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1, '{0, 0, 0, 0}},
        '{'{3'd7, 16'sh1111, -16'sd1, 16'sd1, 16'sh2222}, 1, '{0, 0, 0, 0}}
    };

    initial begin
        operands_t    op;
        cplx_result_t none;
        none = '{0, 0, 0, 0};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (table_rows[i])
            send_word(table_rows[i].op, table_rows[i].typed, table_rows[i].res);
        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 150 && n < 350);
            if (n == 450) begin
                s_valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(negedge aclk);
            end else if (!calm && $urandom_range(99) < 6) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(4, 1)) @(negedge aclk);
            end
            op.act = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                               : 3'($urandom_range(4));
            op.a_re = rand_part();
            op.a_im = rand_part();
            op.b_re = rand_part();
            op.b_im = rand_part();
            if ($urandom_range(15) == 0) begin
                op.b_re = '0;
                op.b_im = '0;
            end
            send_word(op, 1'b0, none);
        end
        s_valid <= 1'b0;
        calm = 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN) @(posedge aclk);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
